[hdl/max_heap_priority_queue_top_macros.svh]
// ----------------------------------------------------------------------------
// Max-heap priority queue: assertion macros
// Shared concurrent check wrappers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define MHPQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MHPQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MHPQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define MHPQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[hdl/mhpq_pkg.sv]
// ----------------------------------------------------------------------------
// Max-heap priority queue: package
// Sizes, codes and the types passed between controller and datapath.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = IDX_W + 2;

  localparam logic [1:0] ACT_APPEND  = 2'd0;
  localparam logic [1:0] ACT_BUILD   = 2'd1;
  localparam logic [1:0] ACT_EXTRACT = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [7:0]  pri;
    logic [6:0]  age;
    logic [15:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_APPEND,
    OP_EX_EMPTY,
    OP_EX_RD_ROOT,
    OP_EX_RD_LAST,
    OP_EX_SETUP,
    OP_BLD_STEP,
    OP_BLD_LOAD,
    OP_SD_RD_LEFT,
    OP_SD_LEFT,
    OP_SD_RIGHT,
    OP_SD_MOVE,
    OP_SD_FINISH,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic left_ok;
    logic right_ok;
    logic best_is_node;
    logic bld_zero;
  } dp_stat_t;

endpackage

[hdl/mhpq_ram.sv]
// ----------------------------------------------------------------------------
// Max-heap priority queue: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/mhpq_dp.sv]
// ----------------------------------------------------------------------------
// Max-heap priority queue: datapath
// Heap store, count, sift-down registers and the result register.
// ----------------------------------------------------------------------------
`include "max_heap_priority_queue_top_macros.svh"

module mhpq_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mhpq_pkg::dp_cmd_t       cmd_i,
  output mhpq_pkg::dp_stat_t      stat_o,
  input  logic [7:0]              priority_req_i,
  input  logic [6:0]              age_i,
  input  logic [15:0]             item_tag_i,
  output logic [1:0]              status_o,
  output logic [7:0]              out_priority_o,
  output logic [6:0]              out_age_o,
  output logic [15:0]             out_tag_o,
  output logic [mhpq_pkg::CNT_W-1:0] entry_count_o
);

  import mhpq_pkg::*;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   node_q, node_d;
  logic [IDX_W-1:0]   bld_i_q, bld_i_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  entry_t             cur_q, cur_d;
  entry_t             best_q, best_d;
  entry_t             in_q, in_d;
  entry_t             got_q, got_d;
  logic [1:0]         res_st_q, res_st_d;
  logic [1:0]         out_st_q, out_st_d;
  entry_t             out_ent_q, out_ent_d;
  logic [CNT_W-1:0]   out_cnt_q, out_cnt_d;

  logic               we, re;
  logic [IDX_W-1:0]   waddr, raddr;
  entry_t             wdata, rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  logic [CHILD_W-1:0] left_idx, right_idx, count_ext;
  logic [CNT_W-1:0]   count_m1;

  assign left_idx  = CHILD_W'({node_q, 1'b1});
  assign right_idx = left_idx + CHILD_W'(1);
  assign count_ext = CHILD_W'(count_q);
  assign count_m1  = count_q - CNT_W'(1);
  assign rdata     = entry_t'(rdata_raw);

  always_comb begin
    stat_o.cnt_zero     = (count_q == '0);
    stat_o.left_ok      = (left_idx < count_ext);
    stat_o.right_ok     = (right_idx < count_ext);
    stat_o.best_is_node = (best_idx_q == node_q);
    stat_o.bld_zero     = (bld_i_q == '0);
  end

  always_comb begin
    count_d    = count_q;
    node_d     = node_q;
    bld_i_d    = bld_i_q;
    best_idx_d = best_idx_q;
    cur_d      = cur_q;
    best_d     = best_q;
    in_d       = in_q;
    got_d      = got_q;
    res_st_d   = res_st_q;
    out_st_d   = out_st_q;
    out_ent_d  = out_ent_q;
    out_cnt_d  = out_cnt_q;
    we         = 1'b0;
    waddr      = '0;
    wdata      = cur_q;
    re         = 1'b0;
    raddr      = '0;

    unique case (cmd_i.op)
      OP_ACCEPT: begin
        in_d     = '{pri: priority_req_i, age: age_i, tag: item_tag_i};
        got_d    = '0;
        res_st_d = ST_OK;
        bld_i_d  = count_q[CNT_W-1:1];
      end
      OP_APPEND: begin
        if (count_q == CNT_W'(CAPACITY)) begin
          res_st_d = ST_FULL;
        end else begin
          we      = 1'b1;
          waddr   = count_q[IDX_W-1:0];
          wdata   = in_q;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_EX_EMPTY: begin
        res_st_d = ST_EMPTY;
      end
      OP_EX_RD_ROOT: begin
        re    = 1'b1;
        raddr = '0;
      end
      OP_EX_RD_LAST: begin
        got_d = rdata;
        re    = 1'b1;
        raddr = count_m1[IDX_W-1:0];
      end
      OP_EX_SETUP: begin
        cur_d   = rdata;
        node_d  = '0;
        count_d = count_m1;
      end
      OP_BLD_STEP: begin
        bld_i_d = bld_i_q - IDX_W'(1);
        node_d  = bld_i_q - IDX_W'(1);
        re      = 1'b1;
        raddr   = bld_i_q - IDX_W'(1);
      end
      OP_BLD_LOAD: begin
        cur_d = rdata;
      end
      OP_SD_RD_LEFT: begin
        re    = 1'b1;
        raddr = left_idx[IDX_W-1:0];
      end
      OP_SD_LEFT: begin
        // left child wins only on strictly greater priority
        if (rdata.pri > cur_q.pri) begin
          best_d     = rdata;
          best_idx_d = left_idx[IDX_W-1:0];
        end else begin
          best_d     = cur_q;
          best_idx_d = node_q;
        end
        re    = 1'b1;
        raddr = right_idx[IDX_W-1:0];
      end
      OP_SD_RIGHT: begin
        if (rdata.pri > best_q.pri) begin
          best_d     = rdata;
          best_idx_d = right_idx[IDX_W-1:0];
        end
      end
      OP_SD_MOVE: begin
        // child moves up, hole follows it down
        we     = 1'b1;
        waddr  = node_q;
        wdata  = best_q;
        node_d = best_idx_q;
      end
      OP_SD_FINISH: begin
        we    = 1'b1;
        waddr = node_q;
        wdata = cur_q;
      end
      OP_EMIT: begin
        out_st_d  = res_st_q;
        out_ent_d = got_q;
        out_cnt_d = count_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q     <= node_d;
    bld_i_q    <= bld_i_d;
    best_idx_q <= best_idx_d;
    cur_q      <= cur_d;
    best_q     <= best_d;
    in_q       <= in_d;
    got_q      <= got_d;
    res_st_q   <= res_st_d;
    out_st_q   <= out_st_d;
    out_ent_q  <= out_ent_d;
    out_cnt_q  <= out_cnt_d;
  end

  mhpq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  assign status_o       = out_st_q;
  assign out_priority_o = out_ent_q.pri;
  assign out_age_o      = out_ent_q.age;
  assign out_tag_o      = out_ent_q.tag;
  assign entry_count_o  = out_cnt_q;

  `MHPQ_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `MHPQ_ASSERT_IMP(a_move_child, clk_i, rst_ni, cmd_i.op == OP_SD_MOVE, best_idx_q > node_q, "sift move not toward a child")

endmodule

[hdl/mhpq_ctrl.sv]
// ----------------------------------------------------------------------------
// Max-heap priority queue: controller
// Sequences append, build and extract; owns the handshakes.
// ----------------------------------------------------------------------------
`include "max_heap_priority_queue_top_macros.svh"

module mhpq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mhpq_pkg::dp_cmd_t  cmd_o,
  input  mhpq_pkg::dp_stat_t stat_i
);

  import mhpq_pkg::*;

  localparam logic [3:0] S_IDLE        = 4'd0;
  localparam logic [3:0] S_APPEND      = 4'd1;
  localparam logic [3:0] S_EX_RD_ROOT  = 4'd2;
  localparam logic [3:0] S_EX_RD_LAST  = 4'd3;
  localparam logic [3:0] S_EX_SETUP    = 4'd4;
  localparam logic [3:0] S_BLD_NEXT    = 4'd5;
  localparam logic [3:0] S_BLD_LOAD    = 4'd6;
  localparam logic [3:0] S_SD_START    = 4'd7;
  localparam logic [3:0] S_SD_LEFT     = 4'd8;
  localparam logic [3:0] S_SD_RIGHT    = 4'd9;
  localparam logic [3:0] S_SD_DECIDE   = 4'd10;
  localparam logic [3:0] S_DONE        = 4'd11;

  logic [3:0] state_q, state_d;
  logic       build_q, build_d;
  logic       out_valid_q, out_valid_d;
  logic       sd_ret_done;
  logic [3:0] sd_ret;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign sd_ret      = build_q ? S_BLD_NEXT : S_DONE;

  always_comb begin
    state_d     = state_q;
    build_d     = build_q;
    out_valid_d = out_valid_q;
    cmd_o.op    = OP_NONE;
    sd_ret_done = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          build_d  = (action_i == ACT_BUILD);
          unique case (action_i)
            ACT_APPEND:  state_d = S_APPEND;
            ACT_BUILD:   state_d = S_BLD_NEXT;
            ACT_EXTRACT: state_d = S_EX_RD_ROOT;
            default:     state_d = S_DONE;
          endcase
        end
      end
      S_APPEND: begin
        cmd_o.op = OP_APPEND;
        state_d  = S_DONE;
      end
      S_EX_RD_ROOT: begin
        if (stat_i.cnt_zero) begin
          cmd_o.op = OP_EX_EMPTY;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_EX_RD_ROOT;
          state_d  = S_EX_RD_LAST;
        end
      end
      S_EX_RD_LAST: begin
        cmd_o.op = OP_EX_RD_LAST;
        state_d  = S_EX_SETUP;
      end
      S_EX_SETUP: begin
        cmd_o.op = OP_EX_SETUP;
        state_d  = S_SD_START;
      end
      S_BLD_NEXT: begin
        if (stat_i.bld_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_BLD_STEP;
          state_d  = S_BLD_LOAD;
        end
      end
      S_BLD_LOAD: begin
        cmd_o.op = OP_BLD_LOAD;
        state_d  = S_SD_START;
      end
      S_SD_START: begin
        if (stat_i.left_ok) begin
          cmd_o.op = OP_SD_RD_LEFT;
          state_d  = S_SD_LEFT;
        end else begin
          cmd_o.op    = OP_SD_FINISH;
          sd_ret_done = 1'b1;
          state_d     = sd_ret;
        end
      end
      S_SD_LEFT: begin
        cmd_o.op = OP_SD_LEFT;
        state_d  = stat_i.right_ok ? S_SD_RIGHT : S_SD_DECIDE;
      end
      S_SD_RIGHT: begin
        cmd_o.op = OP_SD_RIGHT;
        state_d  = S_SD_DECIDE;
      end
      S_SD_DECIDE: begin
        if (stat_i.best_is_node) begin
          cmd_o.op    = OP_SD_FINISH;
          sd_ret_done = 1'b1;
          state_d     = sd_ret;
        end else begin
          cmd_o.op = OP_SD_MOVE;
          state_d  = S_SD_START;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      build_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      build_q     <= build_d;
      out_valid_q <= out_valid_d;
    end
  end

  `MHPQ_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "ready right after a request")
  `MHPQ_ASSERT_NXT(a_done_waits, clk_i, rst_ni, state_q == S_DONE && out_valid_q && !out_ready_i, state_q == S_DONE && out_valid_q, "result overwritten while stalled")
  `MHPQ_ASSERT_IMP(a_sift_return, clk_i, rst_ni, sd_ret_done && !build_q, state_d == S_DONE, "sift finish lost its return")

endmodule

[hdl/max_heap_priority_queue_top.sv]
// Throughput: one request at a time; the heap store serves one access per cycle, so the
//   count of levels sifted sets the rate. A stalled result adds its stall before the next
//   result can be loaded.
// Reset: asynchronous active low; clears the count and handshake state. Store contents stay
//   undefined and need no clearing pass, since only entries below the count are ever used.
// ----------------------------------------------------------------------------
// Max-heap priority queue: top level
// Binary max-heap of {priority, age, tag} entries with append, bottom-up build
// and extract-max. A controller FSM sequences a datapath built around one RAM.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  priority_req_i,
  input  logic [6:0]  age_i,
  input  logic [15:0] item_tag_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  out_priority_o,
  output logic [6:0]  out_age_o,
  output logic [15:0] out_tag_o,
  output logic [mhpq_pkg::CNT_W-1:0] entry_count_o
);

  import mhpq_pkg::*;

  // Command/status link between sequencer and datapath.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller: takes one request at a time (ready only in idle), walks
  // append / extract / build, runs the shared sift-down loop one level per
  // pass (read left, read right, compare, move), and hands the result to
  // the output register. A held result does not block the next request.
  mhpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  // Datapath: heap store RAM, entry count, hole-based sift registers
  // (the sifted entry is written once at its final slot) and the result
  // register that drives the output fields.
  mhpq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .priority_req_i(priority_req_i),
    .age_i         (age_i),
    .item_tag_i    (item_tag_i),
    .status_o      (status_o),
    .out_priority_o(out_priority_o),
    .out_age_o     (out_age_o),
    .out_tag_o     (out_tag_o),
    .entry_count_o (entry_count_o)
  );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-heap priority queue: testbench
// Drives append, build and extract requests through the valid/ready request
// channel. Every result is checked against a typed table row or against a
// software heap kept in step with the block. A short table of hand-picked
// requests comes first, then a store fill under back-pressure, then about a
// thousand random requests under changing idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb;
  import mhpq_pkg::*;

  // Code the block must ignore: status ok, payload zero, count unchanged.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 11;
  localparam int HOLD_CYCLES  = 400;   // long result-side stall during the fill
  localparam int DRAIN_CYCLES = 40;    // longer than an extract at full depth
  localparam int RANDOM_ITEMS = 1000;
  // Slowest legal request is a build over a full store, with every node sifting
  // to the bottom. The limit covers a run where every request is such a build
  // plus the longest gap on each side (86% idle) and the fill stall, doubled
  // for margin.
  localparam int LIMIT_CYCLES = 2_000_000;

  typedef struct packed {
    logic [1:0]       status;
    entry_t           ent;
    logic [CNT_W-1:0] count;
  } heap_result_t;

  // One row of the directed table. When typed is set, want holds the result
  // read straight off the behavior; otherwise the software heap supplies it.
  typedef struct packed {
    logic [1:0]   act;
    entry_t       ent;
    logic         typed;
    heap_result_t want;
  } stim_row_t;

  localparam entry_t E_NONE = '0;
  localparam entry_t E_TOP  = '{8'd255, 7'd127, 16'hFFFF};

  localparam int DIR_ROWS = 24;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // empty store after reset
    '{ACT_EXTRACT, E_NONE, 1'b1, '{ST_EMPTY, E_NONE, 7'd0}},
    '{ACT_BUILD,   E_NONE, 1'b1, '{ST_OK,    E_NONE, 7'd0}},
    '{ACT_UNUSED,  E_TOP,  1'b1, '{ST_OK,    E_NONE, 7'd0}},
    // single entry, all-ones payload, build that moves nothing
    '{ACT_APPEND,  E_TOP,  1'b1, '{ST_OK,    E_NONE, 7'd1}},
    '{ACT_BUILD,   E_NONE, 1'b1, '{ST_OK,    E_NONE, 7'd1}},
    '{ACT_EXTRACT, E_NONE, 1'b1, '{ST_OK,    E_TOP,  7'd0}},
    // all-zero entry; payload on an extract request is don't-care
    '{ACT_APPEND,  E_NONE, 1'b1, '{ST_OK,    E_NONE, 7'd1}},
    '{ACT_EXTRACT, E_TOP,  1'b1, '{ST_OK,    E_NONE, 7'd0}},
    // unbuilt store with ties, so left-before-right and strict compare matter
    '{ACT_APPEND,  '{8'd10,  7'd1, 16'h0001}, 1'b0, '0},
    '{ACT_APPEND,  '{8'd40,  7'd2, 16'h0002}, 1'b0, '0},
    '{ACT_APPEND,  '{8'd40,  7'd3, 16'h0003}, 1'b0, '0},
    '{ACT_APPEND,  '{8'd200, 7'd4, 16'h0004}, 1'b0, '0},
    '{ACT_APPEND,  '{8'd5,   7'd5, 16'h8000}, 1'b0, '0},
    '{ACT_APPEND,  '{8'd200, 7'd6, 16'h0006}, 1'b0, '0},
    // extract before build: root taken as held
    '{ACT_EXTRACT, E_NONE, 1'b0, '0},
    '{ACT_UNUSED,  E_TOP,  1'b0, '0},
    '{ACT_BUILD,   E_NONE, 1'b0, '0},
    '{ACT_EXTRACT, E_NONE, 1'b0, '0},
    '{ACT_EXTRACT, E_NONE, 1'b0, '0},
    '{ACT_APPEND,  '{8'd255, 7'd0, 16'h00FF}, 1'b0, '0},
    '{ACT_EXTRACT, E_NONE, 1'b0, '0},
    '{ACT_BUILD,   E_NONE, 1'b0, '0},
    '{ACT_EXTRACT, E_NONE, 1'b0, '0},
    '{ACT_EXTRACT, E_NONE, 1'b0, '0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [1:0]       action_i;
  logic [7:0]       priority_req_i;
  logic [6:0]       age_i;
  logic [15:0]      item_tag_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [1:0]       status_o;
  logic [7:0]       out_priority_o;
  logic [6:0]       out_age_o;
  logic [15:0]      out_tag_o;
  logic [CNT_W-1:0] entry_count_o;

  max_heap_priority_queue_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .priority_req_i (priority_req_i),
    .age_i          (age_i),
    .item_tag_i     (item_tag_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .out_priority_o (out_priority_o),
    .out_age_o      (out_age_o),
    .out_tag_o      (out_tag_o),
    .entry_count_o  (entry_count_o)
  );

  // Software copy of the heap store and its count.
  entry_t      heap_mem [CAPACITY];
  int unsigned held;

  heap_result_t awaited_results [$];

  int unsigned send_idle;   // percent of cycles the request side sits out
  int unsigned recv_idle;   // percent of cycles the result side stalls
  logic        hold_active;
  event        hold_ev;

  int unsigned errors;
  int unsigned checked;
  int unsigned n_append, n_full, n_build, n_extract, n_empty, n_unused, peak;

  always #HALF_PERIOD clk_i = ~clk_i;

  // Full sift-down: left child tested first, only a strictly greater
  // priority displaces the current best.
  function automatic void sift_from(int unsigned node, int unsigned cnt);
    int unsigned cur, best, lft, rgt;
    entry_t      tmp;
    bit          settled;
    cur     = node;
    settled = 1'b0;
    while (!settled) begin
      lft  = 2 * cur + 1;
      rgt  = 2 * cur + 2;
      best = cur;
      if (lft < cnt && heap_mem[lft].pri > heap_mem[best].pri) best = lft;
      if (rgt < cnt && heap_mem[rgt].pri > heap_mem[best].pri) best = rgt;
      if (best == cur) begin
        settled = 1'b1;
      end else begin
        tmp            = heap_mem[cur];
        heap_mem[cur]  = heap_mem[best];
        heap_mem[best] = tmp;
        cur            = best;
      end
    end
  endfunction

  // Applies one request to the software heap and returns the result it owes.
  function automatic heap_result_t heap_apply(logic [1:0] act, entry_t ent);
    heap_result_t res;
    int unsigned  last;
    entry_t       tmp;
    res = '0;
    case (act)
      ACT_APPEND: begin
        if (held >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          heap_mem[held] = ent;
          held++;
        end
      end
      ACT_BUILD: begin
        for (int i = int'(held / 2) - 1; i >= 0; i--) sift_from(i, held);
      end
      ACT_EXTRACT: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          last           = held - 1;
          tmp            = heap_mem[0];
          heap_mem[0]    = heap_mem[last];
          heap_mem[last] = tmp;
          res.ent        = tmp;
          held           = last;
          sift_from(0, held);
        end
      end
      default: ;
    endcase
    res.count = CNT_W'(held);
    return res;
  endfunction

  // Offers one request and holds it until the block takes it. Valid gets at
  // most one assignment per clock step: it is dropped only when an idle gap
  // is taken, and left high otherwise so back-to-back requests stay packed.
  task automatic offer(input logic [1:0] act, input entry_t ent,
                       input logic typed, input heap_result_t want);
    bit           fire;
    heap_result_t res;
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    priority_req_i <= ent.pri;
    age_i          <= ent.age;
    item_tag_i     <= ent.tag;
    // Ready is looked at mid-cycle, where nothing is moving, so the edge that
    // follows is the one that takes the request.
    do begin
      @(negedge clk_i);
      fire = in_ready_o;
      @(posedge clk_i);
    end while (!fire);
    res = heap_apply(act, ent);
    awaited_results.push_back(typed ? want : res);
    case (act)
      ACT_APPEND:  n_append++;
      ACT_BUILD:   n_build++;
      ACT_EXTRACT: n_extract++;
      default:     n_unused++;
    endcase
    if (res.status == ST_FULL) n_full++;
    if (res.status == ST_EMPTY) n_empty++;
    if (held > peak) peak = held;
  endtask

  // Request side goes quiet until every awaited result has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  function automatic entry_t random_entry();
    entry_t ent;
    case ($urandom_range(3))
      0:       ent.pri = 8'($urandom_range(7));          // dense ties
      1:       ent.pri = $urandom_range(1) ? 8'hFF : 8'h00;
      default: ent.pri = 8'($urandom_range(255));
    endcase
    ent.age = 7'($urandom_range(127));
    ent.tag = 16'($urandom_range(65535));
    return ent;
  endfunction

  // Random traffic in blocks of fifty with a drifting mix: append-heavy
  // blocks push toward a full store, extract-heavy ones drain it to empty.
  // Unused codes are sprinkled in but do not count toward n.
  task automatic random_round(input int unsigned n);
    int unsigned counted, pick, mix;
    logic [1:0]  act;
    counted = 0;
    mix     = 0;
    while (counted < n) begin
      if (counted % 50 == 0) mix = $urandom_range(2);
      pick = $urandom_range(99);
      if (pick < 3) begin
        act = ACT_UNUSED;
      end else begin
        case (mix)
          0:       act = pick < 70 ? ACT_APPEND : (pick < 82 ? ACT_BUILD : ACT_EXTRACT);
          1:       act = pick < 25 ? ACT_APPEND : (pick < 33 ? ACT_BUILD : ACT_EXTRACT);
          default: act = pick < 50 ? ACT_APPEND : (pick < 62 ? ACT_BUILD : ACT_EXTRACT);
        endcase
      end
      offer(act, random_entry(), 1'b0, '0);
      if (act != ACT_UNUSED) counted++;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Result ready: random stalls, forced low while a hold-off is running.
  always @(posedge clk_i) begin
    out_ready_i <= !hold_active && ($urandom_range(99) >= recv_idle);
  end

  // Long result-side hold-off, timed in its own process on the falling edge.
  initial begin
    forever begin
      @(hold_ev);
      @(negedge clk_i);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      hold_active = 1'b0;
    end
  end

  // Result checker: sampled mid-cycle, so the values seen are the ones the
  // next rising edge transfers.
  always @(negedge clk_i) begin
    heap_result_t want, got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status_o, '{out_priority_o, out_age_o, out_tag_o}, entry_count_o};
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing awaited, status %0d count %0d",
                 $time, got.status, got.count);
      end else begin
        want = awaited_results.pop_front();
        checked++;
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("out_priority", 32'(want.ent.pri), 32'(got.ent.pri));
        check_field("out_age", 32'(want.ent.age), 32'(got.ent.age));
        check_field("out_tag", 32'(want.ent.tag), 32'(got.ent.tag));
        check_field("entry_count", 32'(want.count), 32'(got.count));
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("%0t ns: no finish within %0d cycles, %0d results still awaited",
             $time, LIMIT_CYCLES, awaited_results.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    action_i       = ACT_APPEND;
    priority_req_i = '0;
    age_i          = '0;
    item_tag_i     = '0;
    out_ready_i    = 1'b0;
    hold_active    = 1'b0;
    held           = 0;
    errors         = 0;
    checked        = 0;
    n_append       = 0;
    n_full         = 0;
    n_build        = 0;
    n_extract      = 0;
    n_empty        = 0;
    n_unused       = 0;
    peak           = 0;
    // first idle pattern: sparse requests, results mostly stalled
    send_idle      = 33;
    recv_idle      = 86;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (int r = 0; r < DIR_ROWS; r++) begin
      offer(DIRECTED[r].act, DIRECTED[r].ent, DIRECTED[r].typed, DIRECTED[r].want);
    end
    settle();

    // Fill past capacity while the result side is held off: the block sits on
    // an unread result and must stall its request channel. The last few
    // appends hit a full store and must be refused.
    send_idle = 0;
    -> hold_ev;
    for (int k = 0; k < CAPACITY + 4; k++) offer(ACT_APPEND, random_entry(), 1'b0, '0);
    settle();

    // Random traffic under three idle patterns, drained between each.
    send_idle = 33;
    recv_idle = 86;
    random_round(RANDOM_ITEMS / 3);
    settle();
    send_idle = 86;
    recv_idle = 33;
    random_round(RANDOM_ITEMS / 3);
    settle();
    send_idle = 0;
    recv_idle = 0;
    random_round(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    settle();

    // Quiet tail: any stray result shows up in the checker.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d appends (%0d refused on full), %0d builds, %0d extracts (%0d on empty),",
             n_append, n_full, n_build, n_extract, n_empty);
    $display("%0d ignored codes; %0d results checked, occupancy peaked at %0d of %0d.",
             n_unused, checked, peak, CAPACITY);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
